### src/msl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msl_pkg
// Shared types and constants of the multichannel slew limiter.
// ----------------------------------------------------------------------------
package msl_pkg;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [15:0] ONE_Q15 = 16'h8000;
   localparam logic [3:0]  COUNT_MAX = 4'hF;

   localparam logic KIND_STATUS  = 1'b0;
   localparam logic KIND_CHANNEL = 1'b1;

   typedef enum logic [1:0] {
      OP_ENTRY        = 2'd0,
      OP_TICK         = 2'd1,
      OP_SET_FAULT    = 2'd2,
      OP_CLEAR_FAULTS = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_MAX_INDEX = 2'd0,
      REG_FALL_RATE = 2'd1,
      REG_RISE_RATE = 2'd2,
      REG_NONE      = 2'd3
   } reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMD_OUT,
      ST_TICK_MUL,
      ST_TICK_CHAN
   } state_type;

   typedef struct packed {
      logic entry;
      logic commit;
      logic tick_load;
      logic step_load;
      logic emit_status;
      logic emit_chan;
      logic fault_set;
      logic fault_clear;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic chan_last;
   } stat_type;

   typedef struct packed {
      logic [15:0] max_index;
      logic [31:0] fall_rate;
      logic [31:0] rise_rate;
   } cfg_type;

endpackage
`default_nettype wire

### src/multichannel_slew_limiter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_slew_limiter
// Per-channel modulation index slew limiter with staged commands and faults.
//
// Requests enter on req_* (stream, tuser = operation, tlast = entry_last).
// Reports leave on rsp_* (tuser = report kind, tlast = last of a run).
// Command entries other than the last, and fault events, give no report.
// The last entry of a command moves the sequencer to a report state, where
// its status report is registered once the output register is free.
// A tick latches its step, then computes the step multiplies, then updates
// and reports one channel per cycle while the output register is free.
// Input is taken only while the sequencer is idle; a waiting report sits in
// the output register and does not block that. When the receiver stalls the
// sequencer holds until the output register frees.
// Reset (synchronous) clears all channel state, faults and the partial
// command; max_index returns to 1.0, both rates to zero.
// ----------------------------------------------------------------------------
module multichannel_slew_limiter #(
   parameter int CHANNELS = 4
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // chan[3:0] index_request[19:4] channel_on[20] step_us[36:21]
   // all_enable[37] fault_value[38]
   input  wire [msl_pkg::REQ_DATA_W-1:0]    req_tdata,
   // operation[1:0]
   input  wire [1:0]                        req_tuser,
   input  wire                              req_tlast,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // accepted[0] report_channel[3:1] applied_index[19:4]
   // target_index[35:20] channel_enabled[36] channel_faulted[37]
   output logic [msl_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // report_kind[0]
   output logic [0:0]                       rsp_tuser,
   output logic                             rsp_tlast,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire [msl_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire [msl_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [msl_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import msl_pkg::*;

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   msl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   msl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .stat       (stat),
      .cmd        (cmd)
   );

   msl_dp #(
      .CHANNELS (CHANNELS),
      .CH_W     (CH_W)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .cfg        (cfg),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

### src/msl_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msl_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module msl_csr (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             csr_psel,
   input  wire                             csr_penable,
   input  wire                             csr_pwrite,
   input  wire [msl_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire [msl_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [msl_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output msl_pkg::cfg_type                cfg
);
   import msl_pkg::*;

   logic [15:0] max_index_ff, max_index_in;
   logic [31:0] fall_rate_ff, fall_rate_in;
   logic [31:0] rise_rate_ff, rise_rate_in;
   logic        wr_en;
   reg_type     sel;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign sel   = reg_type'(csr_paddr[3:2]);

   always_comb begin
      max_index_in = max_index_ff;
      fall_rate_in = fall_rate_ff;
      rise_rate_in = rise_rate_ff;
      csr_prdata   = '0;
      unique case (sel)
         REG_MAX_INDEX: begin
            csr_prdata = {16'h0000, max_index_ff};
            if (wr_en) max_index_in = csr_pwdata[15:0];
         end
         REG_FALL_RATE: begin
            csr_prdata = fall_rate_ff;
            if (wr_en) fall_rate_in = csr_pwdata;
         end
         REG_RISE_RATE: begin
            csr_prdata = rise_rate_ff;
            if (wr_en) rise_rate_in = csr_pwdata;
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_index_ff <= ONE_Q15;
         fall_rate_ff <= '0;
         rise_rate_ff <= '0;
      end else begin
         max_index_ff <= max_index_in;
         fall_rate_ff <= fall_rate_in;
         rise_rate_ff <= rise_rate_in;
      end
   end

   assign cfg.max_index = (max_index_ff > ONE_Q15) ? ONE_Q15 : max_index_ff;
   assign cfg.fall_rate = fall_rate_ff;
   assign cfg.rise_rate = rise_rate_ff;

endmodule
`default_nettype wire

### src/msl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msl_ctrl
// Sequencer: accepts transactions, steps a tick across channels, and issues
// status and channel reports.
// ----------------------------------------------------------------------------
module msl_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  wire [1:0]           req_tuser,
   input  wire                 req_tlast,
   input  msl_pkg::stat_type   stat,
   output msl_pkg::cmd_type    cmd
);
   import msl_pkg::*;

   state_type state_ff, state_in;
   op_type    op;

   assign op = op_type'(req_tuser);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (op)
                  OP_ENTRY: begin
                     cmd.entry  = 1'b1;
                     cmd.commit = req_tlast;
                     if (req_tlast) state_in = ST_CMD_OUT;
                  end
                  OP_TICK: begin
                     cmd.tick_load = 1'b1;
                     state_in      = ST_TICK_MUL;
                  end
                  OP_SET_FAULT: begin
                     cmd.fault_set = 1'b1;
                  end
                  OP_CLEAR_FAULTS: begin
                     cmd.fault_clear = 1'b1;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CMD_OUT: begin
            if (stat.out_free) begin
               cmd.emit_status = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_TICK_MUL: begin
            cmd.step_load = 1'b1;
            state_in      = ST_TICK_CHAN;
         end
         ST_TICK_CHAN: begin
            if (stat.out_free) begin
               cmd.emit_chan = 1'b1;
               if (stat.chan_last) state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### src/msl_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msl_dp
// Channel state, command staging, step computation and the report register.
// ----------------------------------------------------------------------------
module msl_dp #(
   parameter int CHANNELS = 4,
   parameter int CH_W     = 2
) (
   input  wire                              clock,
   input  wire                              reset,
   input  msl_pkg::cmd_type                 cmd,
   output msl_pkg::stat_type                stat,
   input  msl_pkg::cfg_type                 cfg,
   input  wire [msl_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [msl_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [0:0]                       rsp_tuser,
   output logic                             rsp_tlast
);
   import msl_pkg::*;

   // request fields
   logic [3:0]  f_chan;
   logic [15:0] f_index;
   logic        f_on;
   logic [15:0] f_step;
   logic        f_all_en;
   logic        f_fault;

   assign f_chan   = req_tdata[3:0];
   assign f_index  = req_tdata[19:4];
   assign f_on     = req_tdata[20];
   assign f_step   = req_tdata[36:21];
   assign f_all_en = req_tdata[37];
   assign f_fault  = req_tdata[38];

   logic [15:0] target_ff  [CHANNELS];
   logic [15:0] target_in  [CHANNELS];
   logic [15:0] applied_ff [CHANNELS];
   logic [15:0] applied_in [CHANNELS];
   logic [15:0] pend_t_ff  [CHANNELS];
   logic [15:0] pend_t_in  [CHANNELS];
   logic [CHANNELS-1:0] enable_ff, enable_in;
   logic [CHANNELS-1:0] fault_ff, fault_in;
   logic [CHANNELS-1:0] pend_e_ff, pend_e_in;
   logic [CHANNELS-1:0] seen_ff, seen_in, seen_new;
   logic [3:0]  count_ff, count_in, count_new;
   logic        error_ff, error_in, error_new;
   logic        acc_ff, acc_in;
   logic [15:0] step_ff, step_in;
   logic        all_en_ff, all_en_in;
   logic [15:0] down_ff, down_in;
   logic [15:0] up_ff, up_in;
   logic [CH_W-1:0] chan_ff, chan_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff, out_kind_in;
   logic        out_acc_ff, out_acc_in;
   logic [2:0]  out_chan_ff, out_chan_in;
   logic [15:0] out_applied_ff, out_applied_in;
   logic [15:0] out_target_ff, out_target_in;
   logic        out_en_ff, out_en_in;
   logic        out_fault_ff, out_fault_in;
   logic        out_last_ff, out_last_in;

   logic [CH_W-1:0] idx;
   logic        chan_ok;
   logic        entry_ok;
   logic        cmd_ok;
   logic [47:0] fall_prod;
   logic [47:0] rise_prod;
   logic [15:0] cur_a;
   logic [15:0] cur_t;
   logic [16:0] new_a;
   logic [15:0] new_a_clip;
   logic        out_free;

   function automatic logic [15:0] sat_step(input logic [47:0] p);
      logic [31:0] q;
      q = p[47:16];
      return (q > 32'(ONE_Q15)) ? ONE_Q15 : q[15:0];
   endfunction

   assign idx      = f_chan[CH_W-1:0];
   assign chan_ok  = f_chan < 4'(CHANNELS);
   assign entry_ok = chan_ok && (f_index <= ONE_Q15) && !seen_ff[idx];
   assign seen_new = entry_ok ? (seen_ff | (CHANNELS'(1) << idx)) : seen_ff;
   assign count_new = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + 4'd1;
   assign error_new = error_ff | ~entry_ok;
   assign cmd_ok    = !error_new && (count_new == 4'(CHANNELS)) && (&seen_new);

   assign fall_prod = 48'(cfg.fall_rate) * 48'(step_ff);
   assign rise_prod = 48'(cfg.rise_rate) * 48'(step_ff);

   assign cur_a = applied_ff[chan_ff];
   assign cur_t = target_ff[chan_ff];

   always_comb begin
      if (!all_en_ff || !enable_ff[chan_ff] || fault_ff[chan_ff]) begin
         new_a = '0;
      end else if (cur_t < cur_a) begin
         new_a = ((cur_a - cur_t) > down_ff) ? {1'b0, cur_a - down_ff} : {1'b0, cur_t};
      end else begin
         new_a = ((cur_t - cur_a) > up_ff) ? {1'b0, cur_a} + {1'b0, up_ff}
                                            : {1'b0, cur_t};
      end
      new_a_clip = (new_a > {1'b0, cfg.max_index}) ? cfg.max_index : new_a[15:0];
   end

   assign out_free      = !out_valid_ff || rsp_tready;
   assign stat.out_free  = out_free;
   assign stat.chan_last = chan_ff == CH_W'(CHANNELS - 1);

   always_comb begin
      target_in  = target_ff;
      applied_in = applied_ff;
      pend_t_in  = pend_t_ff;
      enable_in  = enable_ff;
      fault_in   = fault_ff;
      pend_e_in  = pend_e_ff;
      seen_in    = seen_ff;
      count_in   = count_ff;
      error_in   = error_ff;
      acc_in     = acc_ff;
      step_in    = step_ff;
      all_en_in  = all_en_ff;
      down_in    = down_ff;
      up_in      = up_ff;
      chan_in    = chan_ff;

      out_valid_in   = out_valid_ff & ~rsp_tready;
      out_kind_in    = out_kind_ff;
      out_acc_in     = out_acc_ff;
      out_chan_in    = out_chan_ff;
      out_applied_in = out_applied_ff;
      out_target_in  = out_target_ff;
      out_en_in      = out_en_ff;
      out_fault_in   = out_fault_ff;
      out_last_in    = out_last_ff;

      if (cmd.entry) begin
         if (entry_ok) begin
            pend_t_in[idx] = f_index;
            pend_e_in[idx] = f_on;
         end
         if (cmd.commit) begin
            seen_in  = '0;
            count_in = '0;
            error_in = 1'b0;
            acc_in   = cmd_ok;
            if (cmd_ok) begin
               for (int i = 0; i < CHANNELS; i++) begin
                  target_in[i] = (pend_t_in[i] > cfg.max_index) ? cfg.max_index
                                                                : pend_t_in[i];
                  enable_in[i] = pend_e_in[i];
               end
            end
         end else begin
            seen_in  = seen_new;
            count_in = count_new;
            error_in = error_new;
         end
      end

      if (cmd.tick_load) begin
         step_in   = f_step;
         all_en_in = f_all_en;
         chan_in   = '0;
      end

      if (cmd.step_load) begin
         down_in = sat_step(fall_prod);
         up_in   = sat_step(rise_prod);
      end

      if (cmd.fault_set && chan_ok) fault_in[idx] = f_fault;
      if (cmd.fault_clear) fault_in = '0;

      if (cmd.emit_chan) begin
         applied_in[chan_ff] = new_a_clip;
         chan_in        = chan_ff + CH_W'(1);
         out_valid_in   = 1'b1;
         out_kind_in    = KIND_CHANNEL;
         out_acc_in     = 1'b0;
         out_chan_in    = 3'(chan_ff);
         out_applied_in = new_a_clip;
         out_target_in  = cur_t;
         out_en_in      = enable_ff[chan_ff];
         out_fault_in   = fault_ff[chan_ff];
         out_last_in    = stat.chan_last;
      end

      if (cmd.emit_status) begin
         out_valid_in   = 1'b1;
         out_kind_in    = KIND_STATUS;
         out_acc_in     = acc_ff;
         out_chan_in    = '0;
         out_applied_in = '0;
         out_target_in  = '0;
         out_en_in      = 1'b0;
         out_fault_in   = 1'b0;
         out_last_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            target_ff[i]  <= '0;
            applied_ff[i] <= '0;
         end
         enable_ff    <= '0;
         fault_ff     <= '0;
         seen_ff      <= '0;
         count_ff     <= '0;
         error_ff     <= 1'b0;
         chan_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         applied_ff   <= applied_in;
         enable_ff    <= enable_in;
         fault_ff     <= fault_in;
         seen_ff      <= seen_in;
         count_ff     <= count_in;
         error_ff     <= error_in;
         chan_ff      <= chan_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_t_ff      <= pend_t_in;
      pend_e_ff      <= pend_e_in;
      acc_ff         <= acc_in;
      step_ff        <= step_in;
      all_en_ff      <= all_en_in;
      down_ff        <= down_in;
      up_ff          <= up_in;
      out_kind_ff    <= out_kind_in;
      out_acc_ff     <= out_acc_in;
      out_chan_ff    <= out_chan_in;
      out_applied_ff <= out_applied_in;
      out_target_ff  <= out_target_in;
      out_en_ff      <= out_en_in;
      out_fault_ff   <= out_fault_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {2'b00, out_fault_ff, out_en_ff, out_target_ff,
                        out_applied_ff, out_chan_ff, out_acc_ff};

endmodule
`default_nettype wire

### dv/msl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msl_checker
// Watches the request, report and register ports of the slew limiter, keeps
// its own copy of the channel state, predicts every report and compares the
// reports that come out, field by field and in order.
// ----------------------------------------------------------------------------
module msl_checker #(
   parameter int CHANNELS = 4
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   input  wire                              req_tready,
   input  wire [msl_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire [1:0]                        req_tuser,
   input  wire                              req_tlast,
   input  wire                              rsp_tvalid,
   input  wire                              rsp_tready,
   input  wire [msl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire [0:0]                        rsp_tuser,
   input  wire                              rsp_tlast,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire [msl_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire [msl_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   input  wire                              csr_pready,
   output int                               failures,
   output int                               outstanding
);
   import msl_pkg::*;

   typedef struct {
      logic        kind;
      logic        accepted;
      logic [2:0]  chan;
      logic [15:0] applied;
      logic [15:0] target;
      logic        enabled;
      logic        faulted;
      logic        last;
   } report_type;

   report_type  report_q[$];
   cfg_type     cfg;
   logic [15:0] target_idx[CHANNELS];
   logic [15:0] applied_idx[CHANNELS];
   logic        chan_en[CHANNELS];
   logic        chan_flt[CHANNELS];
   logic [15:0] staged_idx[CHANNELS];
   logic        staged_en[CHANNELS];
   logic [7:0]  seen_chans;
   logic [3:0]  entries;
   logic        bad_entry;

   initial failures = 0;

   function automatic logic [15:0] slew_step(logic [31:0] rate, logic [15:0] us);
      logic [47:0] prod;
      prod = ({16'd0, rate} * {32'd0, us}) >> 16;
      return (prod > {32'd0, ONE_Q15}) ? ONE_Q15 : prod[15:0];
   endfunction

   function automatic logic [15:0] index_limit();
      return (cfg.max_index > ONE_Q15) ? ONE_Q15 : cfg.max_index;
   endfunction

   task automatic clear_state();
      cfg.max_index = ONE_Q15;
      cfg.fall_rate = '0;
      cfg.rise_rate = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         target_idx[i]  = '0;
         applied_idx[i] = '0;
         chan_en[i]     = 1'b0;
         chan_flt[i]    = 1'b0;
         staged_idx[i]  = '0;
         staged_en[i]   = 1'b0;
      end
      seen_chans = '0;
      entries    = '0;
      bad_entry  = 1'b0;
      report_q.delete();
   endtask

   task automatic write_reg();
      case (reg_type'(csr_paddr[3:2]))
         REG_MAX_INDEX: cfg.max_index = csr_pwdata[15:0];
         REG_FALL_RATE: cfg.fall_rate = csr_pwdata;
         REG_RISE_RATE: cfg.rise_rate = csr_pwdata;
         default: ;
      endcase
   endtask

   task automatic take_entry(logic [3:0] ch, logic [15:0] idx, logic on, logic last);
      report_type  rep;
      logic        ok;
      logic        accept;
      logic [15:0] lim;
      ok = (ch < CHANNELS) && (idx <= ONE_Q15);
      if (ok && seen_chans[ch[2:0]])
         ok = 1'b0;
      if (ok) begin
         seen_chans[ch[2:0]] = 1'b1;
         staged_idx[ch]      = idx;
         staged_en[ch]       = on;
      end else begin
         bad_entry = 1'b1;
      end
      if (entries < COUNT_MAX)
         entries++;
      if (last) begin
         accept = !bad_entry && (entries == CHANNELS) &&
                  (seen_chans == 8'((1 << CHANNELS) - 1));
         if (accept) begin
            lim = index_limit();
            for (int i = 0; i < CHANNELS; i++) begin
               target_idx[i] = (staged_idx[i] > lim) ? lim : staged_idx[i];
               chan_en[i]    = staged_en[i];
            end
         end
         seen_chans   = '0;
         entries      = '0;
         bad_entry    = 1'b0;
         rep.kind     = KIND_STATUS;
         rep.accepted = accept;
         rep.chan     = '0;
         rep.applied  = '0;
         rep.target   = '0;
         rep.enabled  = 1'b0;
         rep.faulted  = 1'b0;
         rep.last     = 1'b1;
         report_q.push_back(rep);
      end
   endtask

   task automatic take_tick(logic [15:0] us, logic all_en);
      report_type  rep;
      logic [16:0] a;
      logic [15:0] t;
      logic [15:0] lim;
      logic [15:0] down;
      logic [15:0] up;
      lim  = index_limit();
      down = slew_step(cfg.fall_rate, us);
      up   = slew_step(cfg.rise_rate, us);
      for (int i = 0; i < CHANNELS; i++) begin
         a = {1'b0, applied_idx[i]};
         t = target_idx[i];
         if (!all_en || !chan_en[i] || chan_flt[i])
            a = '0;
         else if (t < a)
            a = (a - t > down) ? a - down : {1'b0, t};
         else
            a = (t - a > up) ? a + up : {1'b0, t};
         if (a > lim)
            a = {1'b0, lim};
         applied_idx[i] = a[15:0];
         rep.kind     = KIND_CHANNEL;
         rep.accepted = 1'b0;
         rep.chan     = 3'(i);
         rep.applied  = a[15:0];
         rep.target   = t;
         rep.enabled  = chan_en[i];
         rep.faulted  = chan_flt[i];
         rep.last     = (i == CHANNELS - 1);
         report_q.push_back(rep);
      end
   endtask

   task automatic take_request();
      logic [3:0] ch;
      ch = req_tdata[3:0];
      case (op_type'(req_tuser))
         OP_ENTRY:
            take_entry(ch, req_tdata[19:4], req_tdata[20], req_tlast);
         OP_TICK:
            take_tick(req_tdata[36:21], req_tdata[37]);
         OP_SET_FAULT:
            if (ch < CHANNELS)
               chan_flt[ch] = req_tdata[38];
         OP_CLEAR_FAULTS:
            for (int i = 0; i < CHANNELS; i++)
               chan_flt[i] = 1'b0;
         default: ;
      endcase
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
         failures++;
      end
   endtask

   task automatic check_report();
      report_type want;
      report_type got;
      got.kind     = rsp_tuser[0];
      got.accepted = rsp_tdata[0];
      got.chan     = rsp_tdata[3:1];
      got.applied  = rsp_tdata[19:4];
      got.target   = rsp_tdata[35:20];
      got.enabled  = rsp_tdata[36];
      got.faulted  = rsp_tdata[37];
      got.last     = rsp_tlast;
      if (report_q.size() == 0) begin
         $display("%0t: unexpected report, expected none actual tuser 0x%0h tdata 0x%0h tlast %0b",
                  $time, rsp_tuser, rsp_tdata, rsp_tlast);
         failures++;
      end else begin
         want = report_q.pop_front();
         check_field("report_kind", want.kind, got.kind);
         check_field("accepted", want.accepted, got.accepted);
         check_field("report_channel", want.chan, got.chan);
         check_field("applied_index", want.applied, got.applied);
         check_field("target_index", want.target, got.target);
         check_field("channel_enabled", want.enabled, got.enabled);
         check_field("channel_faulted", want.faulted, got.faulted);
         check_field("last", want.last, got.last);
         check_field("tdata padding", 0, rsp_tdata[RSP_DATA_W-1:38]);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            write_reg();
         if (req_tvalid && req_tready)
            take_request();
         if (rsp_tvalid && rsp_tready)
            check_report();
      end
      outstanding = report_q.size();
   end

endmodule

### dv/multichannel_slew_limiter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_slew_limiter_tb
// Drives commands, ticks and fault events into the slew limiter under random
// idling and backpressure, across several register settings; a checker beside
// the block predicts and compares every report.
// ----------------------------------------------------------------------------
module multichannel_slew_limiter_tb;
   import msl_pkg::*;

   localparam int CHANNELS    = 4;
   localparam int ITEM_TARGET = 410;
   localparam int PHASES      = 6;

   typedef struct {
      op_type      op;
      logic [3:0]  chan;
      logic [15:0] index;
      logic        on;
      logic        last;
      logic [15:0] step_us;
      logic        all_en;
      logic        fault_val;
   } request_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic [1:0]             req_tuser;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [0:0]             rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int   failures;
   int   outstanding;
   logic req_taken = 1'b0;
   logic csr_taken = 1'b0;
   bit   calm = 1'b0;
   int   sent_items = 0;
   int   stall_left = 0;

   multichannel_slew_limiter #(.CHANNELS(CHANNELS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   msl_checker #(.CHANNELS(CHANNELS)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_pready (csr_pready),
      .failures   (failures),
      .outstanding(outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      csr_taken <= csr_psel && csr_penable && csr_pready;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // report backpressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0)
            stall_left = idle_len();
      end
   end

   function automatic request_type noise_item();
      request_type r;
      r.op        = op_type'($urandom_range(0, 3));
      r.chan      = 4'($urandom_range(0, 15));
      r.index     = 16'($urandom_range(0, 65535));
      r.on        = 1'($urandom_range(0, 1));
      r.last      = 1'($urandom_range(0, 1));
      r.step_us   = 16'($urandom_range(0, 65535));
      r.all_en    = 1'($urandom_range(0, 1));
      r.fault_val = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic request_type mk_entry(int ch, int idx, logic on, logic last);
      request_type r;
      r       = noise_item();
      r.op    = OP_ENTRY;
      r.chan  = 4'(ch);
      r.index = 16'(idx);
      r.on    = on;
      r.last  = last;
      return r;
   endfunction

   function automatic request_type mk_tick(int us, logic all_en);
      request_type r;
      r         = noise_item();
      r.op      = OP_TICK;
      r.step_us = 16'(us);
      r.all_en  = all_en;
      return r;
   endfunction

   function automatic request_type mk_fault(int ch, logic val);
      request_type r;
      r           = noise_item();
      r.op        = OP_SET_FAULT;
      r.chan      = 4'(ch);
      r.fault_val = val;
      return r;
   endfunction

   function automatic request_type mk_clear();
      request_type r;
      r    = noise_item();
      r.op = OP_CLEAR_FAULTS;
      return r;
   endfunction

   function automatic int pick_index();
      case ($urandom_range(0, 19))
         0:       return 0;
         1:       return ONE_Q15;
         2:       return ONE_Q15 - 1;
         default: return $urandom_range(0, ONE_Q15);
      endcase
   endfunction

   function automatic int pick_step();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 0;
      if (r == 1)
         return 65535;
      if (r < 6)
         return $urandom_range(0, 255);
      return $urandom_range(0, 65535);
   endfunction

   function automatic request_type random_event();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6)
         return mk_tick(pick_step(), $urandom_range(0, 9) != 0);
      if (r < 9)
         return mk_fault(($urandom_range(0, 4) != 0) ? $urandom_range(0, CHANNELS - 1)
                                                     : $urandom_range(CHANNELS, 15),
                         $urandom_range(0, 1));
      return mk_clear();
   endfunction

   // called on a falling edge; leaves tvalid high after the transaction
   task automatic send(request_type r);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, r.fault_val, r.all_en, r.step_us, r.on, r.index, r.chan};
      req_tuser  <= r.op;
      req_tlast  <= r.last;
      do @(negedge clock); while (!req_taken);
      sent_items++;
   endtask

   task automatic csr_write(reg_type r, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_taken);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(logic [15:0] max_idx, logic [31:0] fall, logic [31:0] rise);
      csr_write(REG_MAX_INDEX, {16'd0, max_idx});
      csr_write(REG_FALL_RATE, fall);
      csr_write(REG_RISE_RATE, rise);
   endtask

   // lets entries and fault events with no report finish as well
   task automatic drain();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (CHANNELS + 4) @(negedge clock);
   endtask

   task automatic random_command();
      request_type run[$];
      int          order[CHANNELS];
      int          flaw;
      int          j;
      int          tmp;
      for (int i = 0; i < CHANNELS; i++)
         order[i] = i;
      for (int i = CHANNELS - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < CHANNELS; i++)
         run.push_back(mk_entry(order[i], pick_index(), $urandom_range(0, 7) != 0, 1'b0));
      flaw = ($urandom_range(0, 9) < 8) ? 0 : $urandom_range(1, 5);
      j    = $urandom_range(1, CHANNELS - 1);
      case (flaw)
         1: run[j].index = 16'($urandom_range(ONE_Q15 + 1, 65535));
         2: run[j].chan  = run[0].chan;
         3: run[j].chan  = 4'($urandom_range(CHANNELS, 15));
         4: run.delete(j);
         5: repeat ($urandom_range(1, 13))
               run.push_back(mk_entry($urandom_range(0, CHANNELS - 1), pick_index(),
                                      $urandom_range(0, 1), 1'b0));
         default: ;
      endcase
      run[run.size() - 1].last = 1'b1;
      foreach (run[i]) begin
         if ($urandom_range(0, 11) == 0)
            send(random_event());
         send(run[i]);
      end
   endtask

   initial begin
      int r;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_ENTRY;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed: reset state, then a full stepping setting
      send(mk_tick(65535, 1'b1));
      drain();
      configure(ONE_Q15, 32'h0001_0000, 32'hFFFF_FFFF);
      send(mk_entry(3, ONE_Q15, 1'b1, 1'b0));
      send(mk_entry(2, 0, 1'b1, 1'b0));
      send(mk_entry(1, 12345, 1'b1, 1'b0));
      send(mk_entry(0, ONE_Q15 - 1, 1'b1, 1'b1));
      send(mk_tick(65535, 1'b1));
      send(mk_entry(1, 100, 1'b1, 1'b0));
      send(mk_entry(0, 200, 1'b0, 1'b0));
      send(mk_entry(2, ONE_Q15 + 1, 1'b1, 1'b0));
      send(mk_entry(3, 300, 1'b1, 1'b1));
      send(mk_entry(0, 5, 1'b1, 1'b0));
      send(mk_entry(0, 6, 1'b1, 1'b1));
      send(mk_entry(15, 65535, 1'b1, 1'b1));
      send(mk_entry(0, 7, 1'b1, 1'b0));
      send(mk_entry(1, 8, 1'b1, 1'b1));
      send(mk_fault(1, 1'b1));
      send(mk_fault(9, 1'b1));
      send(mk_tick(100, 1'b1));
      send(mk_clear());
      send(mk_tick(100, 1'b0));
      send(mk_tick(0, 1'b1));
      send(mk_tick(1000, 1'b1));

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            drain();
            case (phase)
               1: configure(16'd0, 32'hFFFF_FFFF, 32'd0);
               2: configure(16'hFFFF, $urandom_range(1, 32'h3_FFFF),
                            $urandom_range(1, 32'h3_FFFF));
               3: configure(16'($urandom_range(0, ONE_Q15)), $urandom, $urandom);
               4: configure(ONE_Q15, $urandom_range(0, 32'hFFFF), $urandom_range(0, 32'hFFFF));
               default: configure(16'($urandom), $urandom_range(0, 32'h7_FFFF),
                                  $urandom_range(0, 32'h7_FFFF));
            endcase
         end
         while (sent_items < ITEM_TARGET * (phase + 1) / PHASES) begin
            if ($urandom_range(0, 15) == 0)
               calm = !calm;
            r = $urandom_range(0, 99);
            if (r < 50)
               random_command();
            else if (r < 92)
               send(random_event());
            else
               send(noise_item());
         end
      end

      drain();
      if (failures == 0)
         $display("multichannel_slew_limiter_tb: PASS");
      else
         $display("multichannel_slew_limiter_tb: FAIL");
      $finish;
   end

   initial begin
      #1500000;
      $display("multichannel_slew_limiter_tb: FAIL");
      $finish;
   end

endmodule
